### rtl/v2ws_pkg.sv
`default_nettype none

package v2ws_pkg;

	localparam int M_WIDTH     = 16;
	localparam int Q_WIDTH     = M_WIDTH + 1;
	localparam int SPEED_WIDTH = 17;

	localparam logic [M_WIDTH-1:0] MAX_VELOCITY_RESET = 16'd3072;

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} v2ws_flags_t;

endpackage

`default_nettype wire

### rtl/v2ws_front.sv
`default_nettype none

module v2ws_front #(
	parameter int VECTOR_WIDTH = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire signed [VECTOR_WIDTH-1:0]         vec_x,
	input  wire signed [VECTOR_WIDTH-1:0]         vec_y,
	input  wire [v2ws_pkg::M_WIDTH-1:0]           max_velocity,
	output logic                                  dn_valid,
	input  wire                                   dn_ready,
	output logic [2*VECTOR_WIDTH:0]               dn_s,
	output logic [2*(v2ws_pkg::M_WIDTH+VECTOR_WIDTH)-1:0] dn_n,
	output logic [v2ws_pkg::M_WIDTH-1:0]          dn_m,
	output v2ws_pkg::v2ws_flags_t                 dn_flags
);
	import v2ws_pkg::*;

	localparam int W   = VECTOR_WIDTH;
	localparam int SW  = 2 * W + 1;
	localparam int MXW = M_WIDTH + W;
	localparam int HW  = (MXW + 1) / 2;
	localparam int GW  = MXW - HW;
	localparam int NW  = 2 * MXW;

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic              load_s1, load_s2, load_s3, load_s4;

	logic [W-1:0]      ax_s1, ay_s1;
	v2ws_flags_t       flags_s1, flags_s2, flags_s3, flags_s4;
	logic [M_WIDTH-1:0] m_s1, m_s2, m_s3, m_s4;

	logic [2*W-1:0]    x2_s2, y2_s2;
	logic [MXW-1:0]    mx_s2;

	logic [SW-1:0]     s_s3, s_s4;
	logic [2*GW-1:0]   hh_s3;
	logic [MXW-1:0]    hl_s3;
	logic [2*HW-1:0]   ll_s3;

	logic [NW-1:0]     n_s4;

	logic [W-1:0]      ax_c, ay_c;
	v2ws_flags_t       flags_c;
	logic [GW-1:0]     mx_hi_c;
	logic [HW-1:0]     mx_lo_c;

	// a stage takes new data when it is empty or its content moves on
	assign load_s4  = !valid_s4 || dn_ready;
	assign load_s3  = !valid_s3 || load_s4;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_stall = !load_s1;

	always_comb begin
		flags_c.x_neg  = vec_x[W-1];
		flags_c.y_neg  = vec_y[W-1];
		flags_c.x_zero = (vec_x == '0);
		flags_c.y_zero = (vec_y == '0);
		ax_c = vec_x[W-1] ? (~vec_x + W'(1)) : vec_x;
		ay_c = vec_y[W-1] ? (~vec_y + W'(1)) : vec_y;
		mx_hi_c = mx_s2[MXW-1:HW];
		mx_lo_c = mx_s2[HW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
			if (load_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			flags_s1 <= flags_c;
			m_s1     <= max_velocity;
		end
		if (load_s2) begin
			x2_s2    <= (2*W)'(ax_s1) * (2*W)'(ax_s1);
			y2_s2    <= (2*W)'(ay_s1) * (2*W)'(ay_s1);
			mx_s2    <= MXW'(m_s1) * MXW'(ax_s1);
			flags_s2 <= flags_s1;
			m_s2     <= m_s1;
		end
		if (load_s3) begin
			// square of m*|x| taken as three half-width partial products
			s_s3     <= SW'(x2_s2) + SW'(y2_s2);
			hh_s3    <= (2*GW)'(mx_hi_c) * (2*GW)'(mx_hi_c);
			hl_s3    <= MXW'(mx_hi_c) * MXW'(mx_lo_c);
			ll_s3    <= (2*HW)'(mx_lo_c) * (2*HW)'(mx_lo_c);
			flags_s3 <= flags_s2;
			m_s3     <= m_s2;
		end
		if (load_s4) begin
			n_s4     <= (NW'(hh_s3) << (2*HW)) + (NW'(hl_s3) << (HW+1)) + NW'(ll_s3);
			s_s4     <= s_s3;
			flags_s4 <= flags_s3;
			m_s4     <= m_s3;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_s     = s_s4;
	assign dn_n     = n_s4;
	assign dn_m     = m_s4;
	assign dn_flags = flags_s4;

endmodule

`default_nettype wire

### rtl/v2ws_cell.sv
`default_nettype none

module v2ws_cell #(
	parameter int VECTOR_WIDTH = 16,
	parameter int BIT          = 0
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   up_valid,
	output logic                                  up_ready,
	input  wire [2*(v2ws_pkg::M_WIDTH+VECTOR_WIDTH)-1:0] up_r,
	input  wire [2*VECTOR_WIDTH+v2ws_pkg::Q_WIDTH:0] up_a,
	input  wire [v2ws_pkg::Q_WIDTH-1:0]           up_q,
	input  wire [2*VECTOR_WIDTH:0]                up_s,
	input  wire [v2ws_pkg::M_WIDTH-1:0]           up_m,
	input  v2ws_pkg::v2ws_flags_t                 up_flags,
	output logic                                  dn_valid,
	input  wire                                   dn_ready,
	output logic [2*(v2ws_pkg::M_WIDTH+VECTOR_WIDTH)-1:0] dn_r,
	output logic [2*VECTOR_WIDTH+v2ws_pkg::Q_WIDTH:0] dn_a,
	output logic [v2ws_pkg::Q_WIDTH-1:0]          dn_q,
	output logic [2*VECTOR_WIDTH:0]               dn_s,
	output logic [v2ws_pkg::M_WIDTH-1:0]          dn_m,
	output v2ws_pkg::v2ws_flags_t                 dn_flags
);
	import v2ws_pkg::*;

	localparam int W  = VECTOR_WIDTH;
	localparam int SW = 2 * W + 1;
	localparam int NW = 2 * (M_WIDTH + W);
	localparam int AW = SW + Q_WIDTH;
	localparam int DW = SW + 2 * Q_WIDTH;

	logic               valid_q;
	logic [NW-1:0]      r_q;
	logic [AW-1:0]      a_q;
	logic [Q_WIDTH-1:0] q_q;
	logic [SW-1:0]      s_q;
	logic [M_WIDTH-1:0] m_q;
	v2ws_flags_t        flags_q;

	logic               load;
	logic [Q_WIDTH-1:0] t_c;
	logic [DW-1:0]      d_c;
	logic               take_c;

	// r holds m^2 x^2 - q^2 s and a holds q*s, so the growth of q^2 s
	// for a trial bit is a sum of two shifted terms
	always_comb begin
		t_c    = up_q | (Q_WIDTH'(1) << BIT);
		d_c    = (DW'(up_a) << (BIT + 1)) + (DW'(up_s) << (2 * BIT));
		take_c = (t_c <= Q_WIDTH'(up_m)) && (d_c <= DW'(up_r));
	end

	assign load     = !valid_q || dn_ready;
	assign up_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q     <= take_c ? (up_r - d_c[NW-1:0]) : up_r;
			a_q     <= take_c ? (up_a + (AW'(up_s) << BIT)) : up_a;
			q_q     <= take_c ? t_c : up_q;
			s_q     <= up_s;
			m_q     <= up_m;
			flags_q <= up_flags;
		end
	end

	assign dn_valid = valid_q;
	assign dn_r     = r_q;
	assign dn_a     = a_q;
	assign dn_q     = q_q;
	assign dn_s     = s_q;
	assign dn_m     = m_q;
	assign dn_flags = flags_q;

	a_q_within_m: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (q_q <= Q_WIDTH'(m_q)))
		else $error("partial quotient exceeds max velocity");

	a_zero_x_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && flags_q.x_zero && !flags_q.y_zero) |-> (q_q == '0))
		else $error("nonzero slow wheel for a sideways vector");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !dn_ready) |=> (valid_q && $stable(q_q) && $stable(r_q)))
		else $error("cell lost or changed a blocked item");

endmodule

`default_nettype wire

### rtl/v2ws_out.sv
`default_nettype none

module v2ws_out (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 up_valid,
	output logic                                up_ready,
	input  wire [v2ws_pkg::Q_WIDTH-1:0]         up_q,
	input  wire [v2ws_pkg::M_WIDTH-1:0]         up_m,
	input  v2ws_pkg::v2ws_flags_t               up_flags,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [v2ws_pkg::SPEED_WIDTH-1:0] left_speed,
	output logic signed [v2ws_pkg::SPEED_WIDTH-1:0] right_speed
);
	import v2ws_pkg::*;

	logic                   valid_q;
	logic [SPEED_WIDTH-1:0] left_q, right_q;

	logic                   load;
	logic [M_WIDTH-1:0]     half_c;
	logic [Q_WIDTH-1:0]     slow_mag_c;
	logic [SPEED_WIDTH-1:0] slow_c, full_c, full_x_c, left_c, right_c;

	always_comb begin
		half_c = up_m >> 1;
		// backward vectors never turn the slow wheel faster than half speed back
		slow_mag_c = (up_flags.x_neg && (up_q > Q_WIDTH'(half_c))) ? Q_WIDTH'(half_c) : up_q;
		slow_c   = up_flags.x_neg ? (SPEED_WIDTH'(0) - SPEED_WIDTH'(slow_mag_c))
			: SPEED_WIDTH'(slow_mag_c);
		full_c   = SPEED_WIDTH'(up_m);
		full_x_c = up_flags.x_neg ? (SPEED_WIDTH'(0) - full_c) : full_c;
		priority if (up_flags.x_zero && up_flags.y_zero) begin
			left_c  = '0;
			right_c = '0;
		end else if (up_flags.y_zero) begin
			left_c  = full_x_c;
			right_c = full_x_c;
		end else if (up_flags.y_neg) begin
			left_c  = full_c;
			right_c = slow_c;
		end else begin
			left_c  = slow_c;
			right_c = full_c;
		end
	end

	assign load     = !valid_q || !out_stall;
	assign up_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= left_c;
			right_q <= right_c;
		end
	end

	assign out_valid   = valid_q;
	assign left_speed  = left_q;
	assign right_speed = right_q;

endmodule

`default_nettype wire

### rtl/vector_to_wheel_speeds_top.sv
`default_nettype none

// Differential-drive steering: each transfer of a signed heading vector
// (vec_x forward, vec_y leftward) yields one transfer of left and right wheel
// speeds in signed Q8.8. The wheel opposite the side the vector points to runs at
// max_velocity, the other at max_velocity * x / |v| truncated toward zero and
// held no lower than -max_velocity/2; a vector straight ahead or straight back
// drives both wheels at +max_velocity or -max_velocity, and a zero vector
// gives zero speeds. One vector is taken every clock cycle while in_stall is low;
// each passes through the front stages of squaring and partial products, then a
// row of 17 cells that each settle one bit of the slow wheel speed, then the
// output register. Stalls ripple back only through full stages, so bubbles are
// absorbed. max_velocity resets to 3072 and is written with cfg_write/cfg_data;
// the user must write it only while the block holds no items, as the block
// itself does not enforce this.

module vector_to_wheel_speeds_top #(
	parameter int VECTOR_WIDTH = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_write,
	input  wire [v2ws_pkg::M_WIDTH-1:0]         cfg_data,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire signed [VECTOR_WIDTH-1:0]       vec_x,
	input  wire signed [VECTOR_WIDTH-1:0]       vec_y,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [v2ws_pkg::SPEED_WIDTH-1:0] left_speed,
	output logic signed [v2ws_pkg::SPEED_WIDTH-1:0] right_speed
);
	import v2ws_pkg::*;

	localparam int W  = VECTOR_WIDTH;
	localparam int SW = 2 * W + 1;
	localparam int NW = 2 * (M_WIDTH + W);
	localparam int AW = SW + Q_WIDTH;

	logic [M_WIDTH-1:0] max_velocity_q;

	logic               valid_w [Q_WIDTH+1];
	logic               ready_w [Q_WIDTH+1];
	logic [NW-1:0]      r_w     [Q_WIDTH+1];
	logic [AW-1:0]      a_w     [Q_WIDTH+1];
	logic [Q_WIDTH-1:0] q_w     [Q_WIDTH+1];
	logic [SW-1:0]      s_w     [Q_WIDTH+1];
	logic [M_WIDTH-1:0] m_w     [Q_WIDTH+1];
	v2ws_flags_t        flags_w [Q_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_velocity_q <= MAX_VELOCITY_RESET;
		end else if (cfg_write) begin
			max_velocity_q <= cfg_data;
		end
	end

	v2ws_front #(
		.VECTOR_WIDTH(VECTOR_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.max_velocity(max_velocity_q),
		.dn_valid    (valid_w[0]),
		.dn_ready    (ready_w[0]),
		.dn_s        (s_w[0]),
		.dn_n        (r_w[0]),
		.dn_m        (m_w[0]),
		.dn_flags    (flags_w[0])
	);

	assign a_w[0] = '0;
	assign q_w[0] = '0;

	// most significant quotient bit first
	for (genvar i = 0; i < Q_WIDTH; i++) begin : g_cell
		v2ws_cell #(
			.VECTOR_WIDTH(VECTOR_WIDTH),
			.BIT         (Q_WIDTH - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(valid_w[i]),
			.up_ready(ready_w[i]),
			.up_r    (r_w[i]),
			.up_a    (a_w[i]),
			.up_q    (q_w[i]),
			.up_s    (s_w[i]),
			.up_m    (m_w[i]),
			.up_flags(flags_w[i]),
			.dn_valid(valid_w[i+1]),
			.dn_ready(ready_w[i+1]),
			.dn_r    (r_w[i+1]),
			.dn_a    (a_w[i+1]),
			.dn_q    (q_w[i+1]),
			.dn_s    (s_w[i+1]),
			.dn_m    (m_w[i+1]),
			.dn_flags(flags_w[i+1])
		);
	end

	v2ws_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_w[Q_WIDTH]),
		.up_ready   (ready_w[Q_WIDTH]),
		.up_q       (q_w[Q_WIDTH]),
		.up_m       (m_w[Q_WIDTH]),
		.up_flags   (flags_w[Q_WIDTH]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_speed (left_speed),
		.right_speed(right_speed)
	);

endmodule

`default_nettype wire

### tb/tb_vector_to_wheel_speeds_top.sv
`timescale 1ns / 100ps

module tb_vector_to_wheel_speeds_top;

	import v2ws_pkg::*;

	localparam int VW          = 16;
	localparam int PHASE_ITEMS = 154;
	localparam int HOLD_CYCLES = 100;

	typedef struct packed {
		logic signed [SPEED_WIDTH-1:0] left;
		logic signed [SPEED_WIDTH-1:0] right;
	} wheel_pair_t;

	typedef struct {
		logic [VW-1:0] x;
		logic [VW-1:0] y;
		wheel_pair_t   w;
	} pending_speed_t;

	typedef struct {
		logic [VW-1:0] x;
		logic [VW-1:0] y;
		bit            typed;
		wheel_pair_t   w;
	} steer_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_write;
	logic [M_WIDTH-1:0]            cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [VW-1:0]          vec_x;
	logic signed [VW-1:0]          vec_y;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [SPEED_WIDTH-1:0] left_speed;
	logic signed [SPEED_WIDTH-1:0] right_speed;

	pending_speed_t     pending_speeds[$];
	logic [M_WIDTH-1:0] max_vel_model;
	steer_row_t         directed_rows[23];
	logic [M_WIDTH-1:0] cfg_plan[8];

	int mismatches      = 0;
	int vectors_sent    = 0;
	int speeds_checked  = 0;
	int configs_written = 0;
	bit calm_tail       = 1'b0;
	bit hold_request    = 1'b0;

	vector_to_wheel_speeds_top #(
		.VECTOR_WIDTH(VW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_speed (left_speed),
		.right_speed(right_speed)
	);

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	function automatic logic signed [SPEED_WIDTH-1:0] signed_speed(bit neg,
			logic [M_WIDTH-1:0] mag);
		logic [SPEED_WIDTH-1:0] wide;
		wide = {1'b0, mag};
		return neg ? (17'd0 - wide) : wide;
	endfunction

	// slow wheel gets floor(m * |x| / r), found bit by bit with exact squared compares
	function automatic wheel_pair_t steer_wheels(logic [VW-1:0] x, logic [VW-1:0] y,
			logic [M_WIDTH-1:0] m);
		logic [16:0] ax;
		logic [16:0] ay;
		logic [16:0] q;
		logic [16:0] cand;
		logic [16:0] half_m;
		logic [79:0] sum_sq;
		logic [79:0] lhs;
		logic [79:0] rhs;
		bit          xneg;
		bit          yneg;
		wheel_pair_t w;
		xneg   = x[VW-1];
		yneg   = y[VW-1];
		ax     = xneg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
		ay     = yneg ? (17'h10000 - {1'b0, y}) : {1'b0, y};
		half_m = {2'b00, m[M_WIDTH-1:1]};
		if (ax == 0 && ay == 0) begin
			w.left  = '0;
			w.right = '0;
		end else if (ay == 0) begin
			w.left  = signed_speed(xneg, m);
			w.right = w.left;
		end else begin
			sum_sq = 80'(ax) * 80'(ax) + 80'(ay) * 80'(ay);
			rhs    = 80'(m) * 80'(m) * 80'(ax) * 80'(ax);
			q      = '0;
			for (int b = 16; b >= 0; b--) begin
				cand = q | (17'd1 << b);
				lhs  = 80'(cand) * 80'(cand) * sum_sq;
				if (cand <= {1'b0, m} && lhs <= rhs)
					q = cand;
			end
			// turning backward is limited to -max_velocity/2
			if (xneg && q > half_m)
				q = half_m;
			if (yneg) begin
				w.left  = signed_speed(1'b0, m);
				w.right = signed_speed(xneg, q[M_WIDTH-1:0]);
			end else begin
				w.right = signed_speed(1'b0, m);
				w.left  = signed_speed(xneg, q[M_WIDTH-1:0]);
			end
		end
		return w;
	endfunction

	function automatic int pick_gap();
		if (calm_tail)
			return 0;
		if ($urandom_range(3) == 0)
			return $urandom_range(1, 6);
		return 0;
	endfunction

	task automatic send_vector(input logic [VW-1:0] x, input logic [VW-1:0] y,
			input bit typed, input wheel_pair_t typed_w);
		pending_speed_t e;
		int             gap;
		in_valid <= 1'b1;
		vec_x    <= x;
		vec_y    <= y;
		do
			@(posedge clk);
		while (in_stall);
		e.x = x;
		e.y = y;
		e.w = typed ? typed_w : steer_wheels(x, y, max_vel_model);
		pending_speeds.push_back(e);
		vectors_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_speeds();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_speeds.size() != 0);
	endtask

	task automatic write_max_velocity(input logic [M_WIDTH-1:0] value);
		drain_speeds();
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write     <= 1'b0;
		max_vel_model = value;
		configs_written++;
	endtask

	task automatic random_vector(output logic [VW-1:0] x, output logic [VW-1:0] y);
		int          kind;
		logic [VW-1:0] corner[5];
		corner = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		kind   = $urandom_range(99);
		x      = VW'($urandom_range(16'hFFFF));
		y      = VW'($urandom_range(16'hFFFF));
		if (kind < 60) begin
		end else if (kind < 70) begin
			y = '0;
		end else if (kind < 75) begin
			x = '0;
		end else if (kind < 78) begin
			x = '0;
			y = '0;
		end else if (kind < 90) begin
			// short vectors make the quotient search coarse
			x = VW'($urandom_range(15) - 8);
			y = VW'($urandom_range(15) - 8);
		end else begin
			x = corner[$urandom_range(4)];
			y = corner[$urandom_range(4)];
		end
	endtask

	// receiver side: short random stall bursts, one long hold on request
	initial begin : receiver
		int hold_left;
		int burst_left;
		hold_left  = 0;
		burst_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				out_stall    <= 1'b1;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (!calm_tail && $urandom_range(7) == 0) begin
				burst_left = $urandom_range(5);
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_speeds
		pending_speed_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_speeds.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual left %0d right %0d",
					$time, left_speed, right_speed);
				mismatches++;
			end else begin
				e = pending_speeds.pop_front();
				speeds_checked++;
				if (left_speed !== e.w.left) begin
					$display("%0t left_speed for (%0d,%0d): expected %0d, actual %0d",
						$time, $signed(e.x), $signed(e.y), e.w.left, left_speed);
					mismatches++;
				end
				if (right_speed !== e.w.right) begin
					$display("%0t right_speed for (%0d,%0d): expected %0d, actual %0d",
						$time, $signed(e.x), $signed(e.y), e.w.right, right_speed);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#8000000;
		$display("vector_to_wheel_speeds_top: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [VW-1:0] rx;
		logic [VW-1:0] ry;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		vec_x         = '0;
		vec_y         = '0;
		max_vel_model = MAX_VELOCITY_RESET;

		// rows typed in by hand assume max_velocity at its reset value of 3072
		directed_rows = '{
			'{16'h0000, 16'h0000, 1'b1, '{17'sd0,     17'sd0}},
			'{16'h0001, 16'h0000, 1'b1, '{17'sd3072,  17'sd3072}},
			'{16'h7FFF, 16'h0000, 1'b1, '{17'sd3072,  17'sd3072}},
			'{16'hFFFF, 16'h0000, 1'b1, '{-17'sd3072, -17'sd3072}},
			'{16'h8000, 16'h0000, 1'b1, '{-17'sd3072, -17'sd3072}},
			'{16'h0000, 16'h0001, 1'b1, '{17'sd0,     17'sd3072}},
			'{16'h0000, 16'hFFFF, 1'b1, '{17'sd3072,  17'sd0}},
			'{16'h0000, 16'h7FFF, 1'b1, '{17'sd0,     17'sd3072}},
			'{16'h0000, 16'h8000, 1'b1, '{17'sd3072,  17'sd0}},
			'{16'h8000, 16'h0001, 1'b1, '{-17'sd1536, 17'sd3072}},
			'{16'h8000, 16'hFFFF, 1'b1, '{17'sd3072,  -17'sd1536}},
			'{16'h7FFF, 16'h7FFF, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h8000, 16'h8000, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h0003, 16'h0004, 1'b0, '{17'sd0,     17'sd0}},
			'{16'hFFFD, 16'h0004, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h0003, 16'hFFFC, 1'b0, '{17'sd0,     17'sd0}},
			'{16'hFFFD, 16'hFFFC, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h7FFF, 16'h0001, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h0001, 16'h8000, 1'b0, '{17'sd0,     17'sd0}},
			'{16'hFFFF, 16'h0001, 1'b0, '{17'sd0,     17'sd0}},
			'{16'hFFFF, 16'h0002, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h8000, 16'h7FFF, 1'b0, '{17'sd0,     17'sd0}},
			'{16'h7FFF, 16'h8000, 1'b0, '{17'sd0,     17'sd0}}
		};

		cfg_plan = '{16'd0, 16'd65535, 16'd1, 16'd32768,
			16'($urandom_range(65535)), 16'($urandom_range(65535)), 16'd3,
			MAX_VELOCITY_RESET};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_vector(directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
				directed_rows[i].w);

		for (int p = 0; p < 8; p++) begin
			write_max_velocity(cfg_plan[p]);
			if (p == 7)
				calm_tail = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold so the pipeline backs up into in_stall
				if (p == 2 && i == 20)
					hold_request = 1'b1;
				// sender goes quiet until every result is back
				if (p == 3 && i == PHASE_ITEMS / 2)
					drain_speeds();
				random_vector(rx, ry);
				send_vector(rx, ry, 1'b0, '0);
			end
		end

		drain_speeds();
		repeat (40) @(posedge clk);

		$display("%0d heading vectors sent, %0d wheel speed pairs checked", vectors_sent,
			speeds_checked);
		$display("max_velocity written %0d times, zero and full scale included",
			configs_written);
		if (mismatches == 0 && pending_speeds.size() == 0)
			$display("vector_to_wheel_speeds_top: match");
		else
			$display("vector_to_wheel_speeds_top: mismatch");
		$finish;
	end

endmodule
